// File: design/srma_pkg.sv
`timescale 1ns / 1ps
// srma_pkg: widths, constants, cordic arctangent table and types
// shared by srma_cordic and spherical_remap_address; no dependencies
package srma_pkg;

  localparam int COORD_W    = 12;
  localparam int CFG_DIM_W  = 13;
  localparam int FOCAL_W    = 24;
  localparam int LIMIT_W    = 17;
  localparam int INDEX_W    = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 24;

  localparam int MAX_DIM_DEF    = 4096;
  localparam int ANGLE_FRAC_DEF = 16;

  localparam int CORDIC_STEPS = 30;
  localparam int CORDIC_W     = 33;
  localparam int ATAN_W       = 31;
  localparam int TAN_QUO_W    = 31;
  localparam int TAN_DEN_W    = 32;
  localparam int Q8_W         = 32;
  localparam int SQ_IN_W      = 64;
  localparam int RAD_W        = SQ_IN_W / 2;

  localparam logic [31:0] CORDIC_K30 = 32'd652032874;
  localparam logic [31:0] HALF_PI30  = 32'd1686629713;
  localparam logic [31:0] SAT_Q8     = 32'd2147483647;

  localparam logic [CFG_DIM_W-1:0] WIDTH_RST  = 13'd640;
  localparam logic [CFG_DIM_W-1:0] HEIGHT_RST = 13'd480;
  localparam logic [FOCAL_W-1:0]   FOCAL_RST  = 24'd163840;
  localparam logic [LIMIT_W-1:0]   LIMIT_RST  = 17'd0;

  localparam logic [ATAN_W-1:0] ATAN_Q30 [CORDIC_STEPS] = '{
    31'd843314856, 31'd497837829, 31'd263043836, 31'd133525158, 31'd67021686,
    31'd33543515, 31'd16775850, 31'd8388437, 31'd4194282, 31'd2097149,
    31'd1048575, 31'd524287, 31'd262143, 31'd131071, 31'd65535,
    31'd32767, 31'd16383, 31'd8191, 31'd4095, 31'd2047,
    31'd1023, 31'd511, 31'd255, 31'd127, 31'd63,
    31'd31, 31'd15, 31'd7, 31'd3, 31'd1
  };

  typedef logic signed [CORDIC_W-1:0] cw_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_WIDTH  = 3'd0,
    CFG_HEIGHT = 3'd1,
    CFG_FOCAL  = 3'd2,
    CFG_THETA  = 3'd3,
    CFG_PHI    = 3'd4
  } cfg_idx_e;

endpackage

// File: design/srma_div.sv
`timescale 1ns / 1ps
// srma_div: pipelined restoring divider, one quotient bit per stage
// carries a side tag along; uses no package items
module srma_div #(
  parameter int DEN_W = 32,
  parameter int QUO_W = 31,
  parameter int TAG_W = 1
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             vld_i,
  input  logic [DEN_W-1:0] den_i,
  input  logic [DEN_W-1:0] rem_i,
  input  logic [QUO_W-1:0] low_i,
  input  logic [TAG_W-1:0] tag_i,
  output logic             vld_o,
  output logic [QUO_W-1:0] quo_o,
  output logic [TAG_W-1:0] tag_o
);

  logic [QUO_W:0]   vld_q;
  logic [DEN_W-1:0] rem_q  [QUO_W+1];
  logic [DEN_W-1:0] den_q  [QUO_W+1];
  logic [QUO_W-1:0] bits_q [QUO_W+1];
  logic [TAG_W-1:0] tag_q  [QUO_W+1];
  logic [DEN_W-1:0] rem_d  [QUO_W];
  logic [QUO_W-1:0] bits_d [QUO_W];

  for (genvar k = 0; k < QUO_W; k++) begin : g_stage
    logic [DEN_W:0] trial;
    logic           ge;
    assign trial     = {rem_q[k], bits_q[k][QUO_W-1]};
    assign ge        = trial >= {1'b0, den_q[k]};
    assign rem_d[k]  = ge ? DEN_W'(trial - {1'b0, den_q[k]}) : DEN_W'(trial);
    assign bits_d[k] = {bits_q[k][QUO_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[QUO_W-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    rem_q[0]  <= rem_i;
    den_q[0]  <= den_i;
    bits_q[0] <= low_i;
    tag_q[0]  <= tag_i;
    for (int k = 0; k < QUO_W; k++) begin
      rem_q[k+1]  <= rem_d[k];
      den_q[k+1]  <= den_q[k];
      bits_q[k+1] <= bits_d[k];
      tag_q[k+1]  <= tag_q[k];
    end
  end

  assign vld_o = vld_q[QUO_W];
  assign quo_o = bits_q[QUO_W];
  assign tag_o = tag_q[QUO_W];

endmodule

// File: design/srma_cordic.sv
`timescale 1ns / 1ps
// srma_cordic: rotation-mode cordic, one iteration per stage, parallel lanes
// depends on srma_pkg for the arctangent table, gain and word type
module srma_cordic #(
  parameter int LANES = 2
) (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           vld_i,
  input  srma_pkg::cw_t  angle_i [LANES],
  output logic           vld_o,
  output srma_pkg::cw_t  sin_o   [LANES],
  output srma_pkg::cw_t  cos_o   [LANES]
);

  localparam int STEPS = srma_pkg::CORDIC_STEPS;
  localparam int W     = srma_pkg::CORDIC_W;

  logic [STEPS:0] vld_q;
  srma_pkg::cw_t  x_q [STEPS+1][LANES];
  srma_pkg::cw_t  y_q [STEPS+1][LANES];
  srma_pkg::cw_t  z_q [STEPS+1][LANES];
  srma_pkg::cw_t  x_d [STEPS][LANES];
  srma_pkg::cw_t  y_d [STEPS][LANES];
  srma_pkg::cw_t  z_d [STEPS][LANES];

  for (genvar k = 0; k < STEPS; k++) begin : g_step
    localparam srma_pkg::cw_t ATAN_K = srma_pkg::cw_t'(srma_pkg::ATAN_Q30[k]);
    for (genvar l = 0; l < LANES; l++) begin : g_lane
      logic neg;
      assign neg = z_q[k][l][W-1];
      assign x_d[k][l] = neg ? x_q[k][l] + (y_q[k][l] >>> k)
                             : x_q[k][l] - (y_q[k][l] >>> k);
      assign y_d[k][l] = neg ? y_q[k][l] - (x_q[k][l] >>> k)
                             : y_q[k][l] + (x_q[k][l] >>> k);
      assign z_d[k][l] = neg ? z_q[k][l] + ATAN_K : z_q[k][l] - ATAN_K;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STEPS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    for (int l = 0; l < LANES; l++) begin
      x_q[0][l] <= srma_pkg::cw_t'(srma_pkg::CORDIC_K30);
      y_q[0][l] <= '0;
      z_q[0][l] <= angle_i[l];
      for (int k = 0; k < STEPS; k++) begin
        x_q[k+1][l] <= x_d[k][l];
        y_q[k+1][l] <= y_d[k][l];
        z_q[k+1][l] <= z_d[k][l];
      end
    end
  end

  assign vld_o = vld_q[STEPS];

  for (genvar l = 0; l < LANES; l++) begin : g_out
    assign sin_o[l] = y_q[STEPS][l];
    assign cos_o[l] = x_q[STEPS][l];
  end

endmodule

// File: design/srma_isqrt.sv
`timescale 1ns / 1ps
// srma_isqrt: pipelined floor square root, one root bit per stage
// carries a side tag along; uses no package items
module srma_isqrt #(
  parameter int IN_W  = 64,
  parameter int TAG_W = 1
) (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                vld_i,
  input  logic [IN_W-1:0]     rad_i,
  input  logic [TAG_W-1:0]    tag_i,
  output logic                vld_o,
  output logic [IN_W/2-1:0]   root_o,
  output logic [TAG_W-1:0]    tag_o
);

  localparam int STEPS  = IN_W / 2;
  localparam int ROOT_W = IN_W / 2;
  localparam int REM_W  = ROOT_W + 2;

  logic [STEPS:0]    vld_q;
  logic [IN_W-1:0]   val_q  [STEPS+1];
  logic [ROOT_W-1:0] root_q [STEPS+1];
  logic [REM_W-1:0]  rem_q  [STEPS+1];
  logic [TAG_W-1:0]  tag_q  [STEPS+1];
  logic [ROOT_W-1:0] root_d [STEPS];
  logic [REM_W-1:0]  rem_d  [STEPS];

  for (genvar k = 0; k < STEPS; k++) begin : g_stage
    logic [REM_W+1:0] cur;
    logic [REM_W+1:0] trial;
    logic             ge;
    assign cur       = {rem_q[k], val_q[k][IN_W-1:IN_W-2]};
    assign trial     = (REM_W+2)'({root_q[k], 2'b01});
    assign ge        = cur >= trial;
    assign rem_d[k]  = ge ? REM_W'(cur - trial) : REM_W'(cur);
    assign root_d[k] = {root_q[k][ROOT_W-2:0], ge};
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else begin
      vld_q <= {vld_q[STEPS-1:0], vld_i};
    end
  end

  always_ff @(posedge clk_i) begin
    val_q[0]  <= rad_i;
    root_q[0] <= '0;
    rem_q[0]  <= '0;
    tag_q[0]  <= tag_i;
    for (int k = 0; k < STEPS; k++) begin
      val_q[k+1]  <= val_q[k] << 2;
      root_q[k+1] <= root_d[k];
      rem_q[k+1]  <= rem_d[k];
      tag_q[k+1]  <= tag_q[k];
    end
  end

  assign vld_o  = vld_q[STEPS];
  assign root_o = root_q[STEPS];
  assign tag_o  = tag_q[STEPS];

endmodule

// File: design/spherical_remap_address.sv
`timescale 1ns / 1ps
// spherical_remap_address: source pixel address for a theta-phi spherical image
// depends on srma_pkg, srma_div, srma_cordic and srma_isqrt
//
// channel   direction  handshake                    payload
// pixel     in         start & !busy                out_row_i, out_col_i
// result    out        res_strobe_o, one cycle      inside_res_o, src_col_o, src_row_o,
//                                                   src_pixel_index_o
// config    in         cfg_valid_i & cfg_ready_o    cfg_index_i, cfg_data_i
//
// one word per cycle; a word passes through the angle dividers, 30 cordic stages,
// two tangent dividers and the root
// busy stays low and cfg_ready_o stays high; the receiver cannot stall results
// reset clears the valid pipeline and loads the register defaults, no clearing pass
module spherical_remap_address #(
  parameter int MAX_DIM         = srma_pkg::MAX_DIM_DEF,
  parameter int ANGLE_FRAC_BITS = srma_pkg::ANGLE_FRAC_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            start,
  output logic                            busy,
  input  logic [srma_pkg::COORD_W-1:0]    out_row_i,
  input  logic [srma_pkg::COORD_W-1:0]    out_col_i,
  output logic                            res_strobe_o,
  output logic                            inside_res_o,
  output logic [srma_pkg::COORD_W-1:0]    src_col_o,
  output logic [srma_pkg::COORD_W-1:0]    src_row_o,
  output logic [srma_pkg::INDEX_W-1:0]    src_pixel_index_o,
  input  logic                            cfg_valid_i,
  output logic                            cfg_ready_o,
  input  logic [srma_pkg::CFG_IDX_W-1:0]  cfg_index_i,
  input  logic [srma_pkg::CFG_DATA_W-1:0] cfg_data_i
);

  localparam int DIM_W   = $clog2(MAX_DIM + 1);
  localparam int EXT_W   = (DIM_W > srma_pkg::CFG_DIM_W) ? DIM_W : srma_pkg::CFG_DIM_W;
  localparam int SH_NUM  = 31 - ANGLE_FRAC_BITS;
  localparam int SH_LIM  = 30 - ANGLE_FRAC_BITS;
  localparam int PROD_W  = srma_pkg::COORD_W + srma_pkg::LIMIT_W;
  localparam int NUM_W   = PROD_W + SH_NUM;
  localparam int ANG_W   = NUM_W + 1;
  localparam int CW      = srma_pkg::CORDIC_W;
  localparam int QW      = srma_pkg::Q8_W;
  localparam int QUO_W   = srma_pkg::TAN_QUO_W;
  localparam int DEN_W   = srma_pkg::TAN_DEN_W;
  localparam int MAG_W   = CW - 1;
  localparam int XPROD_W = MAG_W + srma_pkg::FOCAL_W;
  localparam int YPROD_W = MAG_W + srma_pkg::RAD_W;
  localparam int XSQ_W   = 2 * (QW - 1);
  localparam int FSQ_W   = 2 * srma_pkg::FOCAL_W;
  localparam int SX_W    = ((QW - 8 > DIM_W) ? QW - 8 : DIM_W) + 2;
  localparam int IDX_W   = 2 * DIM_W;
  localparam int XTAG_W  = 2 * CW + 4;
  localparam int STAG_W  = QW + 2 * CW;
  localparam int YTAG_W  = QW + 4;
  localparam int LATENCY = (NUM_W + 1) + (srma_pkg::CORDIC_STEPS + 1) + (QUO_W + 1)
                         + (srma_pkg::SQ_IN_W / 2 + 1) + (QUO_W + 1) + 5;

  // configuration registers
  logic [srma_pkg::CFG_DIM_W-1:0] width_q, height_q;
  logic [srma_pkg::FOCAL_W-1:0]   focal_q;
  logic [srma_pkg::LIMIT_W-1:0]   theta_q, phi_q;

  assign cfg_ready_o = 1'b1;
  assign busy        = 1'b0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      width_q  <= srma_pkg::WIDTH_RST;
      height_q <= srma_pkg::HEIGHT_RST;
      focal_q  <= srma_pkg::FOCAL_RST;
      theta_q  <= srma_pkg::LIMIT_RST;
      phi_q    <= srma_pkg::LIMIT_RST;
    end else if (cfg_valid_i && cfg_ready_o) begin
      unique case (srma_pkg::cfg_idx_e'(cfg_index_i))
        srma_pkg::CFG_WIDTH:  width_q  <= cfg_data_i[srma_pkg::CFG_DIM_W-1:0];
        srma_pkg::CFG_HEIGHT: height_q <= cfg_data_i[srma_pkg::CFG_DIM_W-1:0];
        srma_pkg::CFG_FOCAL:  focal_q  <= cfg_data_i[srma_pkg::FOCAL_W-1:0];
        srma_pkg::CFG_THETA:  theta_q  <= cfg_data_i[srma_pkg::LIMIT_W-1:0];
        srma_pkg::CFG_PHI:    phi_q    <= cfg_data_i[srma_pkg::LIMIT_W-1:0];
        default: ;
      endcase
    end
  end

  logic [EXT_W-1:0] w_ext, h_ext;
  logic [DIM_W-1:0] w_dim, h_dim;
  assign w_ext = EXT_W'(width_q);
  assign h_ext = EXT_W'(height_q);
  assign w_dim = (w_ext > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(w_ext);
  assign h_dim = (h_ext > EXT_W'(MAX_DIM)) ? DIM_W'(MAX_DIM) : DIM_W'(h_ext);

  function automatic srma_pkg::cw_t to_angle(input logic [NUM_W-1:0]            off,
                                             input logic [srma_pkg::LIMIT_W-1:0] lim,
                                             input logic                         zero);
    logic signed [ANG_W-1:0] a;
    logic signed [ANG_W-1:0] lim30;
    logic signed [ANG_W-1:0] hp;
    lim30 = $signed(ANG_W'(lim) << SH_LIM);
    hp    = $signed(ANG_W'(srma_pkg::HALF_PI30));
    a     = zero ? -lim30 : $signed({1'b0, off}) - lim30;
    if (a > hp) a = hp;
    else if (a < -hp) a = -hp;
    return srma_pkg::cw_t'(a);
  endfunction

  function automatic logic signed [QW-1:0] tan_fix(input logic [QUO_W-1:0] quo,
                                                   input logic neg, input logic szero,
                                                   input logic cpos, input logic ovf);
    logic [QW-1:0] mag;
    if (!cpos) mag = szero ? '0 : srma_pkg::SAT_Q8;
    else       mag = ovf ? srma_pkg::SAT_Q8 : QW'(quo);
    return neg ? -$signed(mag) : $signed(mag);
  endfunction

  function automatic logic signed [SX_W-1:0] q8_trunc(input logic signed [QW-1:0] v);
    logic [QW-1:0]          m;
    logic signed [SX_W-1:0] t;
    m = v[QW-1] ? QW'(-v) : QW'(v);
    t = $signed(SX_W'(m >> 8));
    return v[QW-1] ? -t : t;
  endfunction

  // angle dividers
  logic             acc;
  logic [PROD_W-1:0] prod_t, prod_p;
  logic             dt_vld;
  logic [NUM_W-1:0] quo_t, quo_p;
  logic             zero_w, zero_h;

  assign acc    = start && !busy;
  assign prod_t = PROD_W'(out_col_i) * PROD_W'(theta_q);
  assign prod_p = PROD_W'(out_row_i) * PROD_W'(phi_q);

  srma_div #(.DEN_W(DIM_W), .QUO_W(NUM_W), .TAG_W(1)) u_div_t (
    .clk_i, .rst_ni,
    .vld_i (acc),
    .den_i (w_dim),
    .rem_i ('0),
    .low_i (NUM_W'(prod_t) << SH_NUM),
    .tag_i (w_dim == '0),
    .vld_o (dt_vld),
    .quo_o (quo_t),
    .tag_o (zero_w)
  );

  srma_div #(.DEN_W(DIM_W), .QUO_W(NUM_W), .TAG_W(1)) u_div_p (
    .clk_i, .rst_ni,
    .vld_i (acc),
    .den_i (h_dim),
    .rem_i ('0),
    .low_i (NUM_W'(prod_p) << SH_NUM),
    .tag_i (h_dim == '0),
    .vld_o (),
    .quo_o (quo_p),
    .tag_o (zero_h)
  );

  // sine and cosine of both angles
  srma_pkg::cw_t ang [2];
  srma_pkg::cw_t sn  [2];
  srma_pkg::cw_t cs  [2];
  logic          cd_vld;

  assign ang[0] = to_angle(quo_t, theta_q, zero_w);
  assign ang[1] = to_angle(quo_p, phi_q, zero_h);

  srma_cordic #(.LANES(2)) u_cordic (
    .clk_i, .rst_ni,
    .vld_i   (dt_vld),
    .angle_i (ang),
    .vld_o   (cd_vld),
    .sin_o   (sn),
    .cos_o   (cs)
  );

  // x: sin * focal, then divide by cos
  logic               m1_vld_q;
  logic [XPROD_W-1:0] m1_prod_q;
  logic               m1_neg_q, m1_szero_q, m1_cpos_q;
  logic [DEN_W-1:0]   m1_den_q;
  srma_pkg::cw_t      m1_sp_q, m1_cp_q;
  logic [MAG_W-1:0]   st_mag;

  assign st_mag = sn[0][CW-1] ? MAG_W'(-sn[0]) : MAG_W'(sn[0]);

  always_ff @(posedge clk_i) begin
    m1_prod_q  <= XPROD_W'(st_mag) * XPROD_W'(focal_q);
    m1_neg_q   <= sn[0][CW-1];
    m1_szero_q <= sn[0] == '0;
    m1_cpos_q  <= !cs[0][CW-1] && cs[0] != '0;
    m1_den_q   <= cs[0][DEN_W-1:0];
    m1_sp_q    <= sn[1];
    m1_cp_q    <= cs[1];
  end

  logic [XPROD_W-QUO_W-1:0] x_hi;
  logic                     x_ovf;
  logic                     xd_vld;
  logic [QUO_W-1:0]         x_quo;
  logic [XTAG_W-1:0]        x_tag;

  assign x_hi  = m1_prod_q[XPROD_W-1:QUO_W];
  assign x_ovf = DEN_W'(x_hi) >= m1_den_q;

  srma_div #(.DEN_W(DEN_W), .QUO_W(QUO_W), .TAG_W(XTAG_W)) u_div_x (
    .clk_i, .rst_ni,
    .vld_i (m1_vld_q),
    .den_i (m1_den_q),
    .rem_i (x_ovf ? '0 : DEN_W'(x_hi)),
    .low_i (m1_prod_q[QUO_W-1:0]),
    .tag_i ({m1_sp_q, m1_cp_q, m1_neg_q, m1_szero_q, m1_cpos_q, x_ovf}),
    .vld_o (xd_vld),
    .quo_o (x_quo),
    .tag_o (x_tag)
  );

  // radius: sqrt(x^2 + focal^2)
  logic signed [QW-1:0] xq;
  logic [QW-2:0]        x_mag;
  logic                 q1_vld_q;
  logic signed [QW-1:0] q1_xq_q;
  logic [XSQ_W-1:0]     q1_xsq_q;
  logic [FSQ_W-1:0]     q1_fsq_q;
  srma_pkg::cw_t        q1_sp_q, q1_cp_q;

  assign xq    = tan_fix(x_quo, x_tag[3], x_tag[2], x_tag[1], x_tag[0]);
  assign x_mag = xq[QW-1] ? (QW-1)'(-xq) : (QW-1)'(xq);

  always_ff @(posedge clk_i) begin
    q1_xq_q  <= xq;
    q1_xsq_q <= XSQ_W'(x_mag) * XSQ_W'(x_mag);
    q1_fsq_q <= FSQ_W'(focal_q) * FSQ_W'(focal_q);
    q1_sp_q  <= srma_pkg::cw_t'(x_tag[XTAG_W-1 -: CW]);
    q1_cp_q  <= srma_pkg::cw_t'(x_tag[XTAG_W-CW-1 -: CW]);
  end

  logic                         sq_vld;
  logic [srma_pkg::RAD_W-1:0]   rad;
  logic [STAG_W-1:0]            s_tag;

  srma_isqrt #(.IN_W(srma_pkg::SQ_IN_W), .TAG_W(STAG_W)) u_isqrt (
    .clk_i, .rst_ni,
    .vld_i  (q1_vld_q),
    .rad_i  (srma_pkg::SQ_IN_W'(q1_xsq_q) + srma_pkg::SQ_IN_W'(q1_fsq_q)),
    .tag_i  ({q1_xq_q, q1_sp_q, q1_cp_q}),
    .vld_o  (sq_vld),
    .root_o (rad),
    .tag_o  (s_tag)
  );

  // y: sin * radius, then divide by cos
  srma_pkg::cw_t        s_sp, s_cp;
  logic [MAG_W-1:0]     sp_mag;
  logic                 m3_vld_q;
  logic [YPROD_W-1:0]   m3_prod_q;
  logic                 m3_neg_q, m3_szero_q, m3_cpos_q;
  logic [DEN_W-1:0]     m3_den_q;
  logic signed [QW-1:0] m3_xq_q;

  assign s_sp   = srma_pkg::cw_t'(s_tag[2*CW-1 -: CW]);
  assign s_cp   = srma_pkg::cw_t'(s_tag[CW-1:0]);
  assign sp_mag = s_sp[CW-1] ? MAG_W'(-s_sp) : MAG_W'(s_sp);

  always_ff @(posedge clk_i) begin
    m3_prod_q  <= YPROD_W'(sp_mag) * YPROD_W'(rad);
    m3_neg_q   <= s_sp[CW-1];
    m3_szero_q <= s_sp == '0;
    m3_cpos_q  <= !s_cp[CW-1] && s_cp != '0;
    m3_den_q   <= s_cp[DEN_W-1:0];
    m3_xq_q    <= $signed(s_tag[STAG_W-1 -: QW]);
  end

  logic [YPROD_W-QUO_W-1:0] y_hi;
  logic                     y_ovf;
  logic                     yd_vld;
  logic [QUO_W-1:0]         y_quo;
  logic [YTAG_W-1:0]        y_tag;

  assign y_hi  = m3_prod_q[YPROD_W-1:QUO_W];
  assign y_ovf = y_hi >= (YPROD_W-QUO_W)'(m3_den_q);

  srma_div #(.DEN_W(DEN_W), .QUO_W(QUO_W), .TAG_W(YTAG_W)) u_div_y (
    .clk_i, .rst_ni,
    .vld_i (m3_vld_q),
    .den_i (m3_den_q),
    .rem_i (y_ovf ? '0 : DEN_W'(y_hi)),
    .low_i (m3_prod_q[QUO_W-1:0]),
    .tag_i ({m3_xq_q, m3_neg_q, m3_szero_q, m3_cpos_q, y_ovf}),
    .vld_o (yd_vld),
    .quo_o (y_quo),
    .tag_o (y_tag)
  );

  // source coordinates and bounds
  logic signed [QW-1:0]   yq, yx;
  logic signed [SX_W-1:0] sx, sy;
  logic                   in_img;
  logic                   o1_vld_q, o1_in_q;
  logic [DIM_W-1:0]       o1_sx_q, o1_sy_q;

  assign yq = tan_fix(y_quo, y_tag[3], y_tag[2], y_tag[1], y_tag[0]);
  assign yx = $signed(y_tag[YTAG_W-1 -: QW]);
  assign sx = $signed(SX_W'(w_dim >> 1)) + q8_trunc(yx);
  assign sy = $signed(SX_W'(h_dim >> 1)) + q8_trunc(yq);
  assign in_img = !sx[SX_W-1] && (sx < $signed(SX_W'(w_dim)))
               && !sy[SX_W-1] && (sy < $signed(SX_W'(h_dim)));

  always_ff @(posedge clk_i) begin
    o1_in_q <= in_img;
    o1_sx_q <= DIM_W'(sx);
    o1_sy_q <= DIM_W'(sy);
  end

  logic [IDX_W-1:0]                idx;
  logic                            res_strobe_q, inside_q;
  logic [srma_pkg::COORD_W-1:0]    col_q, row_q;
  logic [srma_pkg::INDEX_W-1:0]    index_q;

  assign idx = IDX_W'(o1_sy_q) * IDX_W'(w_dim) + IDX_W'(o1_sx_q);

  always_ff @(posedge clk_i) begin
    inside_q <= o1_in_q;
    col_q    <= o1_in_q ? srma_pkg::COORD_W'(o1_sx_q) : '0;
    row_q    <= o1_in_q ? srma_pkg::COORD_W'(o1_sy_q) : '0;
    index_q  <= o1_in_q ? srma_pkg::INDEX_W'(idx) : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      m1_vld_q     <= 1'b0;
      q1_vld_q     <= 1'b0;
      m3_vld_q     <= 1'b0;
      o1_vld_q     <= 1'b0;
      res_strobe_q <= 1'b0;
    end else begin
      m1_vld_q     <= cd_vld;
      q1_vld_q     <= xd_vld;
      m3_vld_q     <= sq_vld;
      o1_vld_q     <= yd_vld;
      res_strobe_q <= o1_vld_q;
    end
  end

  assign res_strobe_o      = res_strobe_q;
  assign inside_res_o      = inside_q;
  assign src_col_o         = col_q;
  assign src_row_o         = row_q;
  assign src_pixel_index_o = index_q;

  a_black_fill: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o && !inside_res_o |->
      src_col_o == '0 && src_row_o == '0 && src_pixel_index_o == '0)
    else $error("outside result is not black fill");

  a_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_strobe_o == $past(acc, LATENCY))
    else $error("result strobe does not follow accepted word");

  a_inside_bounds: assert property (@(posedge clk_i) disable iff (!rst_ni)
    o1_vld_q && o1_in_q |-> o1_sx_q < w_dim && o1_sy_q < h_dim)
    else $error("inside flag with out of range source");

endmodule
